FILE: rtl/twls_pkg.sv
// twls_pkg: shared types, constants and helpers of the text word/line scanner
// used by every module of the scanner; no dependencies
package twls_pkg;

  localparam int MAX_CHARS = 65536;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [16:0] CNT_MAX = 17'((MAX_CHARS < 131071) ? MAX_CHARS : 131071);
  localparam logic [15:0] IDX_MAX = 16'(((MAX_CHARS - 1) < 65535) ? (MAX_CHARS - 1) : 65535);

  localparam logic [15:0] CHAR_TAB = 16'h0009;
  localparam logic [15:0] CHAR_LF  = 16'h000A;
  localparam logic [15:0] CHAR_CR  = 16'h000D;
  localparam logic [15:0] CHAR_SP  = 16'h0020;
  localparam logic [15:0] CHAR_NEL = 16'h0085;
  localparam logic [15:0] CHAR_LS  = 16'h2028;
  localparam logic [15:0] CHAR_PS  = 16'h2029;

  typedef enum logic [1:0] {
    KIND_WORD = 2'd0,
    KIND_LINE = 2'd1,
    KIND_SUM  = 2'd2
  } record_kind_e;

  typedef enum logic [1:0] {
    PH_SLOT0 = 2'd0,
    PH_SLOT1 = 2'd1,
    PH_SUM   = 2'd2
  } phase_e;

  typedef struct packed {
    record_kind_e kind;
    logic [15:0]  start;
    logic [16:0]  len;
    logic [16:0]  word_total;
    logic [16:0]  line_total;
    logic [16:0]  nonspace_total;
  } span_rec_t;

  // records caused by one input word, in output order
  typedef struct packed {
    logic        v0;
    logic        v1;
    logic        vs;
    span_rec_t   r0;
    span_rec_t   r1;
    logic [16:0] sum_word;
    logic [16:0] sum_line;
    logic [16:0] sum_nonspace;
  } job_t;

  function automatic logic [16:0] sat_inc(input logic [16:0] v);
    return (v < CNT_MAX) ? (v + 17'd1) : CNT_MAX;
  endfunction

endpackage

FILE: rtl/text_word_line_scanner.sv
// text_word_line_scanner: word and line span scanner for utf-16 code units
// path: the records of an input word pass through the record queue, then the registered output stage
// throughput: one input word per cycle while the record queue has room;
// the output stage sends one record per cycle while m_axis_tready does not hold it
// reset: async active-low reset clears runs, totals, queue and the mode bit
// depends on twls_pkg, twls_front, twls_queue, twls_back
module text_word_line_scanner import twls_pkg::*; #(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,     // extended_newlines
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // char_code
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,   // span_start, span_length, word_total,
                                      // line_total, nonspace_total, zero pad
  output logic [1:0]  m_axis_tuser,   // record_kind
  output logic        m_axis_tlast
);

  logic in_accept, push, pop, full, empty;
  job_t job, head;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !full;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  twls_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_accept_i (in_accept),
    .char_code_i (s_axis_tdata),
    .last_char_i (s_axis_tlast),
    .push_o      (push),
    .job_o       (job)
  );

  twls_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (job),
    .pop_i       (pop),
    .head_o      (head),
    .full_o      (full),
    .empty_o     (empty)
  );

  twls_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .empty_i       (empty),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

FILE: rtl/twls_front.sv
// twls_front: classifies each code unit, tracks open runs and totals,
// and hands the records of one word to the queue; depends on twls_pkg
module twls_front import twls_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_data_i,
  input  logic        in_accept_i,
  input  logic [15:0] char_code_i,
  input  logic        last_char_i,
  output logic        push_o,
  output job_t        job_o
);

  logic        ext_q;
  logic        in_word_q, in_word_d;
  logic        in_line_q, in_line_d;
  logic [15:0] wb_q, wb_d, lb_q, lb_d;
  logic [16:0] wl_q, wl_d, ll_q, ll_d;
  logic [16:0] pos_q, pos_d, wc_q, wc_d, lc_q, lc_d, ns_q, ns_d;

  logic        nl, sp, l1, w1, l2, w2, in_line1, in_word1;
  logic [15:0] start_idx, lb1, wb1;
  logic [16:0] ll1, wl1, lc1, wc1, ns1, lc2, wc2, pos1;
  span_rec_t   rec_l1, rec_w1, rec_l2, rec_w2;

  always_comb begin
    nl = (char_code_i == CHAR_LF) || (char_code_i == CHAR_CR) ||
         (ext_q && ((char_code_i == CHAR_LS) || (char_code_i == CHAR_PS) ||
                    (char_code_i == CHAR_NEL)));
    sp = nl || (char_code_i == CHAR_SP) || (char_code_i == CHAR_TAB);
    start_idx = (pos_q < {1'b0, IDX_MAX}) ? pos_q[15:0] : IDX_MAX;

    // line step
    l1       = nl && in_line_q;
    lc1      = l1 ? sat_inc(lc_q) : lc_q;
    in_line1 = !nl;
    lb1      = nl ? 16'd0 : (in_line_q ? lb_q : start_idx);
    ll1      = nl ? 17'd0 : sat_inc(ll_q);

    // word step
    w1       = sp && in_word_q;
    wc1      = w1 ? sat_inc(wc_q) : wc_q;
    in_word1 = !sp;
    wb1      = sp ? 16'd0 : (in_word_q ? wb_q : start_idx);
    wl1      = sp ? 17'd0 : sat_inc(wl_q);
    ns1      = sp ? ns_q : sat_inc(ns_q);
    pos1     = sat_inc(pos_q);

    // flush on last unit
    l2  = last_char_i && in_line1;
    lc2 = l2 ? sat_inc(lc1) : lc1;
    w2  = last_char_i && in_word1;
    wc2 = w2 ? sat_inc(wc1) : wc1;

    rec_l1 = '{kind: KIND_LINE, start: lb_q, len: ll_q, word_total: wc_q,
               line_total: lc1, nonspace_total: ns_q};
    rec_w1 = '{kind: KIND_WORD, start: wb_q, len: wl_q, word_total: wc1,
               line_total: lc1, nonspace_total: ns_q};
    rec_l2 = '{kind: KIND_LINE, start: lb1, len: ll1, word_total: wc1,
               line_total: lc2, nonspace_total: ns1};
    rec_w2 = '{kind: KIND_WORD, start: wb1, len: wl1, word_total: wc2,
               line_total: lc2, nonspace_total: ns1};

    job_o.v0 = l1 || w1 || l2 || w2;
    job_o.v1 = (l1 && w1) || (l1 && w2) || (w1 && l2) || (l2 && w2);
    job_o.vs = last_char_i;
    if (l1) begin
      job_o.r0 = rec_l1;
    end else if (w1) begin
      job_o.r0 = rec_w1;
    end else if (l2) begin
      job_o.r0 = rec_l2;
    end else begin
      job_o.r0 = rec_w2;
    end
    if (l1 && w1) begin
      job_o.r1 = rec_w1;
    end else if (w1 && l2) begin
      job_o.r1 = rec_l2;
    end else begin
      job_o.r1 = rec_w2;
    end
    job_o.sum_word     = wc2;
    job_o.sum_line     = lc2;
    job_o.sum_nonspace = ns1;

    push_o = in_accept_i && (l1 || w1 || last_char_i);

    if (last_char_i) begin
      in_word_d = 1'b0;
      in_line_d = 1'b0;
      wb_d      = '0;
      lb_d      = '0;
      wl_d      = '0;
      ll_d      = '0;
      pos_d     = '0;
      wc_d      = '0;
      lc_d      = '0;
      ns_d      = '0;
    end else begin
      in_word_d = in_word1;
      in_line_d = in_line1;
      wb_d      = wb1;
      lb_d      = lb1;
      wl_d      = wl1;
      ll_d      = ll1;
      pos_d     = pos1;
      wc_d      = wc1;
      lc_d      = lc1;
      ns_d      = ns1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_q     <= 1'b0;
      in_word_q <= 1'b0;
      in_line_q <= 1'b0;
      wb_q      <= '0;
      lb_q      <= '0;
      wl_q      <= '0;
      ll_q      <= '0;
      pos_q     <= '0;
      wc_q      <= '0;
      lc_q      <= '0;
      ns_q      <= '0;
    end else begin
      if (cfg_valid_i) begin
        ext_q <= cfg_data_i;
      end
      if (in_accept_i) begin
        in_word_q <= in_word_d;
        in_line_q <= in_line_d;
        wb_q      <= wb_d;
        lb_q      <= lb_d;
        wl_q      <= wl_d;
        ll_q      <= ll_d;
        pos_q     <= pos_d;
        wc_q      <= wc_d;
        lc_q      <= lc_d;
        ns_q      <= ns_d;
      end
    end
  end

endmodule

FILE: rtl/twls_queue.sv
// twls_queue: short fifo of per-word record bundles between front and back
// depends on twls_pkg
module twls_queue import twls_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  input  logic pop_i,
  output job_t head_o,
  output logic full_o,
  output logic empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  job_t          mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CNT_FULL);
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

FILE: rtl/twls_back.sv
// twls_back: walks the records of the queue head one per cycle, while the output is
// not stalled, into the registered output stage; depends on twls_pkg
module twls_back import twls_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  job_t        head_i,
  input  logic        empty_i,
  output logic        pop_o,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  phase_e      phase_q, phase_d, phase_eff;
  logic        load, done;
  span_rec_t   rec;
  logic        out_valid_q;
  span_rec_t   out_rec_q;
  logic        out_last_q;

  assign load = !empty_i && (!out_valid_q || m_axis_tready);

  // next phase
  always_comb begin
    phase_eff = head_i.v0 ? phase_q : PH_SUM;
    done      = 1'b1;
    phase_d   = phase_q;
    case (phase_eff)
      PH_SLOT0: begin
        if (head_i.v1) begin
          done    = 1'b0;
          phase_d = PH_SLOT1;
        end else if (head_i.vs) begin
          done    = 1'b0;
          phase_d = PH_SUM;
        end
      end
      PH_SLOT1: begin
        if (head_i.vs) begin
          done    = 1'b0;
          phase_d = PH_SUM;
        end
      end
      default: begin
        done = 1'b1;
      end
    endcase
    if (done) begin
      phase_d = PH_SLOT0;
    end
  end

  // record selection
  always_comb begin
    case (phase_eff)
      PH_SLOT0: rec = head_i.r0;
      PH_SLOT1: rec = head_i.r1;
      default: begin
        rec = '{kind: KIND_SUM, start: 16'd0, len: 17'd0,
                word_total: head_i.sum_word, line_total: head_i.sum_line,
                nonspace_total: head_i.sum_nonspace};
      end
    endcase
    pop_o = load && done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SLOT0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        phase_q     <= phase_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_rec_q  <= rec;
      out_last_q <= done;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_rec_q.kind;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {4'd0, out_rec_q.nonspace_total, out_rec_q.line_total,
                          out_rec_q.word_total, out_rec_q.len, out_rec_q.start};

endmodule
